// ===== src/ech_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECH configuration parser package
// Shared types and constants for the byte-serial ECH config parser.
// ----------------------------------------------------------------------------
package ech_pkg;

  // A blob shorter than this many bytes is reported as short.
  localparam logic [3:0] MIN_BLOB_BYTES = 4'd10;

  // Saturation limit of the suite counter.
  localparam logic [13:0] SUITE_COUNT_MAX = 14'h3FFF;

  // Configuration register indexes.
  localparam logic REG_FALLBACK_KDF  = 1'b0;
  localparam logic REG_FALLBACK_AEAD = 1'b1;

  // Parser phase within one blob.
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_KEY,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_SUITES,
    PH_TRAIL
  } phase_t;

  // Kind of a result item.
  typedef enum logic [1:0] {
    KIND_KEY,
    KIND_SUITE,
    KIND_STATUS
  } kind_t;

  // Final status of a blob.
  typedef enum logic [1:0] {
    ST_OK,
    ST_SHORT,
    ST_KEY_TRUNC
  } status_t;

  // Up to three result items caused by one input byte: a key byte or a parsed
  // suite, a fallback suite, and the closing status item.
  typedef struct packed {
    logic          prim_valid;
    logic          prim_suite;
    logic [7:0]    prim_key;
    logic [15:0]   prim_kdf;
    logic [15:0]   prim_aead;
    logic [15:0]   kem;
    logic          fb_valid;
    logic          st_valid;
    logic [15:0]   version;
    logic [7:0]    ident;
    status_t       status;
    logic [13:0]   count;
  } bundle_t;

endpackage

// ===== src/ech_parse_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECH parser core
// Holds the per-blob parse state and forms the result bundle for each byte.
// ----------------------------------------------------------------------------
module ech_parse_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output ech_pkg::bundle_t bundle
);

  ech_pkg::phase_t phase, phase_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [15:0] field_hold, field_hold_next;
  logic [15:0] version_hold, version_hold_next;
  logic [7:0]  ident_hold, ident_hold_next;
  logic [15:0] kem_hold, kem_hold_next;
  logic [15:0] key_left, key_left_next;
  logic [15:0] suite_bytes_left, suite_bytes_left_next;
  logic [15:0] kdf_hold, kdf_hold_next;
  logic [13:0] suites_seen, suites_seen_next;
  logic [1:0]  suite_pos, suite_pos_next;

  // State registers; updated only on an input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= ech_pkg::PH_HEADER;
      byte_count       <= '0;
      field_hold       <= '0;
      version_hold     <= '0;
      ident_hold       <= '0;
      kem_hold         <= '0;
      key_left         <= '0;
      suite_bytes_left <= '0;
      kdf_hold         <= '0;
      suites_seen      <= '0;
      suite_pos        <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      byte_count       <= byte_count_next;
      field_hold       <= field_hold_next;
      version_hold     <= version_hold_next;
      ident_hold       <= ident_hold_next;
      kem_hold         <= kem_hold_next;
      key_left         <= key_left_next;
      suite_bytes_left <= suite_bytes_left_next;
      kdf_hold         <= kdf_hold_next;
      suites_seen      <= suites_seen_next;
      suite_pos        <= suite_pos_next;
    end
  end

  // Next state and result bundle for the byte on the input.
  always_comb begin
    phase_next            = phase;
    byte_count_next       = byte_count;
    field_hold_next       = {field_hold[7:0], data_byte};
    version_hold_next     = version_hold;
    ident_hold_next       = ident_hold;
    kem_hold_next         = kem_hold;
    key_left_next         = key_left;
    suite_bytes_left_next = suite_bytes_left;
    kdf_hold_next         = kdf_hold;
    suites_seen_next      = suites_seen;
    suite_pos_next        = suite_pos;

    bundle            = '0;
    bundle.kem        = kem_hold;
    bundle.prim_key   = data_byte;
    bundle.prim_kdf   = kdf_hold;
    bundle.prim_aead  = field_hold_next;
    bundle.status     = ech_pkg::ST_OK;

    case (phase)
      ech_pkg::PH_HEADER: begin
        // Header fields are picked out by their byte position.
        if (byte_count == 4'd1) begin
          version_hold_next = field_hold_next;
        end else if (byte_count == 4'd2) begin
          ident_hold_next = data_byte;
        end else if (byte_count == 4'd4) begin
          kem_hold_next = field_hold_next;
        end else if (byte_count >= 4'd6) begin
          key_left_next = field_hold_next;
          phase_next    = (field_hold_next != '0) ? ech_pkg::PH_KEY : ech_pkg::PH_LEN_HI;
        end
      end
      ech_pkg::PH_KEY: begin
        bundle.prim_valid = 1'b1;
        key_left_next     = key_left - 16'd1;
        if (key_left == 16'd1) begin
          phase_next = ech_pkg::PH_LEN_HI;
        end
      end
      ech_pkg::PH_LEN_HI: begin
        phase_next = ech_pkg::PH_LEN_LO;
      end
      ech_pkg::PH_LEN_LO: begin
        suite_bytes_left_next = field_hold_next;
        suite_pos_next        = '0;
        phase_next = (field_hold_next != '0) ? ech_pkg::PH_SUITES : ech_pkg::PH_TRAIL;
      end
      ech_pkg::PH_SUITES: begin
        if (suite_pos == 2'd1) begin
          kdf_hold_next = field_hold_next;
        end
        // The fourth byte of a pair completes one suite.
        if (suite_pos == 2'd3) begin
          bundle.prim_valid = 1'b1;
          bundle.prim_suite = 1'b1;
          if (suites_seen != ech_pkg::SUITE_COUNT_MAX) begin
            suites_seen_next = suites_seen + 14'd1;
          end
        end
        suite_pos_next        = suite_pos + 2'd1;
        suite_bytes_left_next = suite_bytes_left - 16'd1;
        if (suite_bytes_left == 16'd1) begin
          phase_next = ech_pkg::PH_TRAIL;
        end
      end
      default: begin
      end
    endcase

    if (byte_count < ech_pkg::MIN_BLOB_BYTES) begin
      byte_count_next = byte_count + 4'd1;
    end

    // Closing status and optional fallback suite on the last byte.
    bundle.version = version_hold_next;
    bundle.ident   = ident_hold_next;
    bundle.count   = suites_seen_next;
    if (last_byte) begin
      bundle.st_valid = 1'b1;
      if (byte_count_next < ech_pkg::MIN_BLOB_BYTES) begin
        bundle.status = ech_pkg::ST_SHORT;
      end else if ((phase_next == ech_pkg::PH_HEADER) || (phase_next == ech_pkg::PH_KEY)) begin
        bundle.status = ech_pkg::ST_KEY_TRUNC;
      end else begin
        bundle.status = ech_pkg::ST_OK;
      end
      if ((bundle.status == ech_pkg::ST_OK) && (suites_seen_next == '0)) begin
        bundle.fb_valid = 1'b1;
        bundle.count    = 14'd1;
      end
      // The next byte starts a fresh blob.
      phase_next            = ech_pkg::PH_HEADER;
      byte_count_next       = '0;
      field_hold_next       = '0;
      version_hold_next     = '0;
      ident_hold_next       = '0;
      kem_hold_next         = '0;
      key_left_next         = '0;
      suite_bytes_left_next = '0;
      kdf_hold_next         = '0;
      suites_seen_next      = '0;
      suite_pos_next        = '0;
    end
  end

endmodule

// ===== src/ech_config_stream_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECH configuration stream parser
// Parses an ECH config blob byte by byte into key bytes, suites and a status.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (data_valid / data_stall) carries one blob byte per
//   transfer, with last_byte set on the final byte. The result channel
//   (result_valid / result_stall) carries key bytes, cipher suites and one
//   closing status item per blob, in blob order.
//   Each byte is parsed in the cycle of its transfer; its results appear in
//   the result register on the next cycle.
//   A byte causes zero to three results. The result register holds them and
//   sends one per cycle unless the receiver stalls; a new byte is taken
//   while results are pending only in the cycle the last of them transfers.
//   Throughput is therefore one byte per cycle for bytes with at most one
//   result; otherwise the next byte waits for the last result to transfer.
//   When the receiver stalls, the current result holds and the input stalls
//   once the pending results cannot drain.
//   Reset clears the parse state and pending results, loads both fallback
//   registers with 1. The user writes them via write_enable / reg_index /
//   write_data only while the block is idle; the block does not enforce it.
//   On a failed status, key bytes already sent belong to a bad blob.
// ----------------------------------------------------------------------------
module ech_config_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic        reg_index,
  input  logic [15:0] write_data,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  key_byte,
  output logic [15:0] kem_id,
  output logic [15:0] kdf_id,
  output logic [15:0] aead_id,
  output logic [15:0] version,
  output logic [7:0]  config_ident,
  output logic [1:0]  status,
  output logic [13:0] suite_count,
  output logic        last_result
);

  logic             in_xfer;
  logic             out_xfer;
  logic             one_left;
  ech_pkg::bundle_t bundle_new;
  ech_pkg::bundle_t held;
  logic             prim_valid, fb_valid, st_valid;
  logic [15:0]      fallback_kdf;
  logic [15:0]      fallback_aead;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fallback_kdf  <= 16'd1;
      fallback_aead <= 16'd1;
    end else if (write_enable) begin
      if (reg_index == ech_pkg::REG_FALLBACK_KDF) begin
        fallback_kdf <= write_data;
      end else begin
        fallback_aead <= write_data;
      end
    end
  end

  // Handshake: accept a byte when nothing is pending or the last pending
  // result transfers in this cycle.
  assign result_valid = prim_valid | fb_valid | st_valid;
  assign out_xfer     = result_valid & ~result_stall;
  assign one_left     = $countones({prim_valid, fb_valid, st_valid}) == 1;
  assign data_stall   = result_valid & ~(one_left & ~result_stall);
  assign in_xfer      = data_valid & ~data_stall;

  ech_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_xfer),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .bundle    (bundle_new)
  );

  // Pending result flags; the earliest one leaves on each output transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      prim_valid <= 1'b0;
      fb_valid   <= 1'b0;
      st_valid   <= 1'b0;
    end else if (in_xfer) begin
      prim_valid <= bundle_new.prim_valid;
      fb_valid   <= bundle_new.fb_valid;
      st_valid   <= bundle_new.st_valid;
    end else if (out_xfer) begin
      if (prim_valid) begin
        prim_valid <= 1'b0;
      end else if (fb_valid) begin
        fb_valid <= 1'b0;
      end else begin
        st_valid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      held <= bundle_new;
    end
  end

  // Output selection for the earliest pending result.
  always_comb begin
    result_kind  = ech_pkg::KIND_STATUS;
    key_byte     = '0;
    kem_id       = '0;
    kdf_id       = '0;
    aead_id      = '0;
    version      = '0;
    config_ident = '0;
    status       = '0;
    suite_count  = '0;
    last_result  = 1'b0;
    if (prim_valid) begin
      if (held.prim_suite) begin
        result_kind = ech_pkg::KIND_SUITE;
        kem_id      = held.kem;
        kdf_id      = held.prim_kdf;
        aead_id     = held.prim_aead;
      end else begin
        result_kind = ech_pkg::KIND_KEY;
        key_byte    = held.prim_key;
      end
    end else if (fb_valid) begin
      result_kind = ech_pkg::KIND_SUITE;
      kem_id      = held.kem;
      kdf_id      = fallback_kdf;
      aead_id     = fallback_aead;
    end else if (st_valid) begin
      result_kind  = ech_pkg::KIND_STATUS;
      version      = held.version;
      config_ident = held.ident;
      status       = held.status;
      suite_count  = held.count;
      last_result  = 1'b1;
    end
  end

  // A byte may only overtake pending results as the last one drains.
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && result_valid) |-> (one_left && !result_stall))
    else $error("input transfer while results still pending");

  // The fallback suite only precedes an ok status.
  assert property (@(posedge clk) disable iff (rst)
    fb_valid |-> (st_valid && held.status == ech_pkg::ST_OK))
    else $error("fallback suite without an ok status");

  // An ok status always reports at least one suite.
  assert property (@(posedge clk) disable iff (rst)
    (st_valid && held.status == ech_pkg::ST_OK) |-> (held.count != '0))
    else $error("ok status with no suite");

  // A status item with pending results never vanishes without a transfer.
  assert property (@(posedge clk) disable iff (rst)
    (st_valid && !out_xfer) |=> st_valid)
    else $error("status item lost");

endmodule
